// ===== rtl/utf8_to_utf16_bmp_decoder_assert.svh =====
// Assertion macros used by the decoder top level.
`ifndef UTF8_TO_UTF16_BMP_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_BMP_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/utf8dec_pkg.sv =====
// Types, constants and byte classification for the UTF-8 decoder.
`default_nettype none

package utf8dec_pkg;

   localparam int unsigned MAX_CAPACITY = 4096;
   localparam int unsigned CAP_W        = 13;
   localparam int unsigned IDX_W        = 12;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] REPLACEMENT = 16'hFFFD;
   localparam logic [15:0] BMP_MAX     = 16'hFFFF;
   localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY);

   // register addresses (word index)
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_BAD
   } lead_class_type;

   typedef struct packed {
      logic [15:0]      code_unit;
      logic [IDX_W-1:0] unit_index;
      logic             is_terminator;
   } result_type;

   typedef struct packed {
      logic [1:0] count;    // number of valid entries, first filled first
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              room;   // space for a two-result transaction
   } queue_status_type;

   function automatic lead_class_type classify_lead(input logic [7:0] b);
      lead_class_type c;
      if (b[7] == 1'b0) begin
         c = LEAD_ASCII;
      end else if ((b & 8'hE0) == 8'hC0) begin
         c = LEAD_TWO;
      end else if ((b & 8'hF0) == 8'hE0) begin
         c = LEAD_THREE;
      end else if ((b & 8'hF8) == 8'hF0) begin
         c = LEAD_FOUR;
      end else begin
         c = LEAD_BAD;
      end
      return c;
   endfunction

   function automatic logic is_continuation(input logic [7:0] b);
      return (b & 8'hC0) == 8'h80;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8dec_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds results.
`default_nettype none

module utf8dec_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic [7:0]                     req_in_byte,
   output logic                                req_stall,
   input  wire logic [utf8dec_pkg::CAP_W-1:0]  capacity,
   input  wire utf8dec_pkg::queue_status_type  q_status,
   output utf8dec_pkg::push_type               push
);

   logic [1:0]                     pending_ff, pending_in;
   logic [20:0]                    partial_ff, partial_in;
   logic [utf8dec_pkg::IDX_W-1:0]  units_ff, units_in;

   logic                           accept;
   logic                           handle_lead;
   logic [20:0]                    shifted;
   logic [utf8dec_pkg::IDX_W-1:0]  cur_units;
   logic [utf8dec_pkg::CAP_W-1:0]  cap_eff;
   logic                           has_room;
   utf8dec_pkg::result_type        lead_res;
   logic                           lead_emit;
   utf8dec_pkg::lead_class_type    lclass;

   assign req_stall = !q_status.room;
   assign accept    = req_valid && q_status.room;
   assign cap_eff   = (capacity > utf8dec_pkg::CAP_LIMIT) ? utf8dec_pkg::CAP_LIMIT : capacity;
   assign shifted   = {partial_ff[14:0], req_in_byte[5:0]};
   assign lclass    = utf8dec_pkg::classify_lead(req_in_byte);

   always_comb begin
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      units_in    = units_ff;
      cur_units   = units_ff;
      handle_lead = 1'b1;
      lead_emit   = 1'b0;
      lead_res    = '0;
      has_room    = 1'b0;
      push        = '0;

      if (pending_ff != 2'd0) begin
         if (utf8dec_pkg::is_continuation(req_in_byte)) begin
            handle_lead = 1'b0;
            pending_in  = pending_ff - 2'd1;
            partial_in  = shifted;
            if (pending_ff == 2'd1) begin
               partial_in          = '0;
               push.count          = 2'd1;
               push.first.code_unit = (shifted > {5'd0, utf8dec_pkg::BMP_MAX}) ?
                                      utf8dec_pkg::REPLACEMENT : shifted[15:0];
               push.first.unit_index = units_ff;
               units_in            = units_ff + 1'b1;
            end
         end else begin
            // broken sequence: replacement, then the byte starts over
            push.count            = 2'd1;
            push.first.code_unit  = utf8dec_pkg::REPLACEMENT;
            push.first.unit_index = units_ff;
            cur_units             = units_ff + 1'b1;
            units_in              = cur_units;
            pending_in            = 2'd0;
            partial_in            = '0;
         end
      end

      if (handle_lead) begin
         has_room = ({1'b0, cur_units} + 1'b1) < cap_eff;
         if (req_in_byte == 8'd0) begin
            lead_emit              = 1'b1;
            lead_res.code_unit     = 16'd0;
            lead_res.unit_index    = cur_units;
            lead_res.is_terminator = 1'b1;
            pending_in             = 2'd0;
            partial_in             = '0;
            units_in               = '0;
         end else if (has_room) begin
            lead_res.unit_index = cur_units;
            unique case (lclass)
               utf8dec_pkg::LEAD_ASCII: begin
                  lead_emit          = 1'b1;
                  lead_res.code_unit = {8'd0, req_in_byte};
                  units_in           = cur_units + 1'b1;
               end
               utf8dec_pkg::LEAD_TWO: begin
                  partial_in = {16'd0, req_in_byte[4:0]};
                  pending_in = 2'd1;
               end
               utf8dec_pkg::LEAD_THREE: begin
                  partial_in = {17'd0, req_in_byte[3:0]};
                  pending_in = 2'd2;
               end
               utf8dec_pkg::LEAD_FOUR: begin
                  partial_in = {18'd0, req_in_byte[2:0]};
                  pending_in = 2'd3;
               end
               default: begin
                  lead_emit          = 1'b1;
                  lead_res.code_unit = utf8dec_pkg::REPLACEMENT;
                  units_in           = cur_units + 1'b1;
               end
            endcase
         end
      end

      if (lead_emit) begin
         if (push.count == 2'd0) begin
            push.first = lead_res;
         end else begin
            push.second = lead_res;
         end
         push.count = push.count + 2'd1;
      end

      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         partial_ff <= '0;
         units_ff   <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         units_ff   <= units_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/utf8dec_queue.sv =====
// Result queue between front and back: takes up to two entries, gives one.
`default_nettype none

module utf8dec_queue (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire utf8dec_pkg::push_type          push,
   input  wire logic                           pop,
   output utf8dec_pkg::result_type             head,
   output logic                                head_valid,
   output utf8dec_pkg::queue_status_type       status
);

   localparam int unsigned QD = utf8dec_pkg::QUEUE_DEPTH;
   localparam int unsigned PW = utf8dec_pkg::QPTR_W;
   localparam int unsigned CW = utf8dec_pkg::QCNT_W;

   utf8dec_pkg::result_type entry_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;

   assign wr_next      = wr_ptr_ff + 1'b1;
   assign head         = entry_ff[rd_ptr_ff];
   assign head_valid   = count_ff != '0;
   assign status.count = count_ff;
   assign status.room  = count_ff <= CW'(QD - 2);

   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/utf8dec_back.sv =====
// Back end: output register that presents queued results downstream.
`default_nettype none

module utf8dec_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire utf8dec_pkg::result_type        head,
   input  wire logic                           head_valid,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [15:0]                         rsp_code_unit,
   output logic [utf8dec_pkg::IDX_W-1:0]       rsp_unit_index,
   output logic                                rsp_is_terminator
);

   logic                    valid_ff, valid_in;
   utf8dec_pkg::result_type data_ff;
   logic                    free;

   assign free     = !valid_ff || !rsp_stall;
   assign pop      = head_valid && free;
   assign valid_in = free ? head_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_code_unit     = data_ff.code_unit;
   assign rsp_unit_index    = data_ff.unit_index;
   assign rsp_is_terminator = data_ff.is_terminator;

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_bmp_decoder.sv =====
// Top level: UTF-8 byte stream to 16-bit BMP code units.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_byte[7:0]
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_code_unit, rsp_unit_index, rsp_is_terminator
//   csr     | in        | psel/penable/pwrite  | paddr[2:0], pwdata, prdata (capacity at 0x0)
//
// One byte per cycle is taken while the result queue has room for two entries.
// A byte that yields two results passes them one after the other through the single output register.
// An accepted byte's result is registered by the queue write and then by the output register.
// Reset is synchronous; capacity returns to 256 and the string state clears.
// rsp_stall holds the output register; the 4-entry queue then fills and stalls req.
`default_nettype none

module utf8_to_utf16_bmp_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_in_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [15:0]                         rsp_code_unit,
   output logic [utf8dec_pkg::IDX_W-1:0]       rsp_unit_index,
   output logic                                rsp_is_terminator,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

`include "utf8_to_utf16_bmp_decoder_assert.svh"

   logic [utf8dec_pkg::CAP_W-1:0] capacity_ff;
   logic                          csr_write;
   utf8dec_pkg::push_type         push;
   utf8dec_pkg::queue_status_type q_status;
   utf8dec_pkg::result_type       head;
   logic                          head_valid;
   logic                          pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == utf8dec_pkg::REG_CAPACITY) ?
                      {{(32 - utf8dec_pkg::CAP_W){1'b0}}, capacity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= utf8dec_pkg::CAP_W'(256);
      end else if (csr_write && paddr[2] == utf8dec_pkg::REG_CAPACITY) begin
         capacity_ff <= pwdata[utf8dec_pkg::CAP_W-1:0];
      end
   end

   utf8dec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .capacity    (capacity_ff),
      .q_status    (q_status),
      .push        (push)
   );

   utf8dec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .status     (q_status)
   );

   utf8dec_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .head_valid        (head_valid),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_unit_index    (rsp_unit_index),
      .rsp_is_terminator (rsp_is_terminator)
   );

   `U8D_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, q_status.count <= utf8dec_pkg::QUEUE_DEPTH, "result queue overflow")
   `U8D_ASSERT_NEXT(a_push_fits, clock, reset, push.count == 2'd2, q_status.count != 3'd0, "double push lost")
   `U8D_ASSERT_IMPLY(a_term_zero, clock, reset, rsp_valid && rsp_is_terminator, rsp_code_unit == 16'd0, "terminator with nonzero unit")
   `U8D_ASSERT_IMPLY(a_index_bound, clock, reset, rsp_valid && !rsp_is_terminator, rsp_unit_index != 12'hFFF, "unit index past capacity")

endmodule

`default_nettype wire

// ===== sim/utf8_to_utf16_bmp_decoder_test.sv =====
// Self-checking testbench for the UTF-8 to BMP code unit decoder.
`default_nettype none

import utf8dec_pkg::*;

class utf8_unit_scoreboard;
   logic [CAP_W-1:0] capacity;
   logic [1:0]       seq_left;
   logic [20:0]      seq_value;
   int unsigned      unit_count;
   result_type       units_due[$];
   int unsigned      errors;
   int unsigned      bytes_seen;
   int unsigned      units_seen;
   int unsigned      strings_done;
   int unsigned      replacements;
   int unsigned      dropped;
   int unsigned      capacity_writes;

   function new();
      capacity = CAP_W'(256);   // value after reset
      clear_string();
      errors = 0;
      bytes_seen = 0;
      units_seen = 0;
      strings_done = 0;
      replacements = 0;
      dropped = 0;
      capacity_writes = 0;
   endfunction

   function void clear_string();
      seq_left = 2'd0;
      seq_value = '0;
      unit_count = 0;
   endfunction

   function void set_capacity(input logic [CAP_W-1:0] value);
      capacity = value;
      capacity_writes++;
   endfunction

   task report(input string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
   endtask

   function void expect_unit(input logic [15:0] value, input logic term);
      result_type r;
      r.code_unit = value;
      r.unit_index = unit_count[IDX_W-1:0];
      r.is_terminator = term;
      units_due.push_back(r);
      if (!term) begin
         if (value == REPLACEMENT) replacements++;
         unit_count++;
      end
   endfunction

   // Decode one accepted byte and queue the units it yields.
   function void take_byte(input logic [7:0] b);
      int unsigned limit;
      limit = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;
      bytes_seen++;
      if (seq_left != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            seq_value = {seq_value[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
               expect_unit((seq_value > 21'(BMP_MAX)) ? REPLACEMENT : seq_value[15:0], 1'b0);
               seq_value = '0;
            end
            return;
         end
         // sequence broken: replacement, then this byte starts over
         expect_unit(REPLACEMENT, 1'b0);
         seq_left = 2'd0;
         seq_value = '0;
      end
      if (b == 8'h00) begin
         expect_unit(16'h0000, 1'b1);
         strings_done++;
         clear_string();
         return;
      end
      if (unit_count + 1 < limit) begin
         if (b[7] == 1'b0) begin
            expect_unit({8'h00, b}, 1'b0);
         end else if (b[7:5] == 3'b110) begin
            seq_value = {16'h0000, b[4:0]};
            seq_left = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            seq_value = {17'h00000, b[3:0]};
            seq_left = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            seq_value = {18'h00000, b[2:0]};
            seq_left = 2'd3;
         end else begin
            expect_unit(REPLACEMENT, 1'b0);
         end
      end else begin
         dropped++;
      end
   endfunction

   task check_unit(input logic [15:0] code, input logic [IDX_W-1:0] index, input logic term);
      result_type want;
      if (units_due.size() == 0) begin
         report($sformatf("unit %h index %0d term %b with nothing expected", code, index, term));
         return;
      end
      want = units_due.pop_front();
      units_seen++;
      if (code !== want.code_unit)
         report($sformatf("code_unit %h, expected %h (index %0d)", code, want.code_unit,
                          want.unit_index));
      if (index !== want.unit_index)
         report($sformatf("unit_index %0d, expected %0d", index, want.unit_index));
      if (term !== want.is_terminator)
         report($sformatf("is_terminator %b, expected %b (index %0d)", term, want.is_terminator,
                          want.unit_index));
   endtask
endclass

module utf8_to_utf16_bmp_decoder_test;

   localparam int unsigned RANDOM_BYTES   = 820;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned LONG_STRING    = 300;

   localparam logic [7:0] OPENING [24] = '{
      8'h00, 8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
      8'hF0, 8'h9F, 8'h98, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hED,
      8'hA0, 8'h80, 8'hFF, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h00
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_in_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [15:0]      rsp_code_unit;
   logic [IDX_W-1:0] rsp_unit_index;
   logic             rsp_is_terminator;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [2:0]       paddr = 3'd0;
   logic [31:0]      pwdata = 32'd0;
   logic [31:0]      prdata;
   logic             pready;

   logic             pacing_on = 1'b1;
   int unsigned      bytes_sent = 0;
   int unsigned      quiet_cycles;

   utf8_unit_scoreboard sb = new();

   utf8_to_utf16_bmp_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_unit_index    (rsp_unit_index),
      .rsp_is_terminator (rsp_is_terminator),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= pacing_on && ($urandom_range(99) < 29);
   end

   // transaction monitor: results are checked before the byte of the same edge is decoded
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_unit(rsp_code_unit, rsp_unit_index, rsp_is_terminator);
         if (req_valid && !req_stall)
            sb.take_byte(req_in_byte);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("utf8_to_utf16_bmp_decoder_test: FAIL");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b);
      while (pacing_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.units_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_CAPACITY, 2'b00};
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_capacity(value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] tail_byte();
      return {2'b10, 6'($urandom_range(63))};
   endfunction

   // Mostly well-formed text with some bad leads, stray and truncated sequences.
   task automatic send_random_string(input int unsigned chars);
      int unsigned roll;
      int unsigned tails;
      repeat (chars) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            send_byte(8'($urandom_range(1, 127)));
         end else if (roll < 55) begin
            send_byte({3'b110, 5'($urandom_range(31))});
            send_byte(tail_byte());
         end else if (roll < 70) begin
            send_byte({4'b1110, 4'($urandom_range(15))});
            repeat (2) send_byte(tail_byte());
         end else if (roll < 80) begin
            send_byte({5'b11110, 3'($urandom_range(7))});
            repeat (3) send_byte(tail_byte());
         end else if (roll < 85) begin
            send_byte(8'($urandom_range(248, 255)));
         end else if (roll < 90) begin
            send_byte(tail_byte());
         end else if (roll < 95) begin
            tails = $urandom_range(2);
            send_byte({5'b11110, 3'($urandom_range(7))});
            repeat (tails) send_byte(tail_byte());
         end else begin
            send_byte(8'($urandom_range(1, 255)));
         end
      end
      send_byte(8'h00);
   endtask

   initial begin
      int unsigned random_start;
      logic [CAP_W-1:0] cap_pick;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes, every lead class, value above the BMP, surrogate, broken sequences
      foreach (OPENING[i]) send_byte(OPENING[i]);

      // a sequence opened under one capacity still emits its unit after the capacity drops
      drain();
      write_capacity(CAP_W'(3));
      send_byte(8'h41);
      send_byte(8'hE2);
      send_byte(8'h82);
      drain();
      write_capacity(CAP_W'(1));
      send_byte(8'hAC);
      send_byte(8'h41);
      send_byte(8'h00);

      // capacity zero behaves like one
      drain();
      write_capacity(CAP_W'(0));
      send_byte(8'h41);
      send_byte(8'hC3);
      send_byte(8'h00);
      drain();
      write_capacity(CAP_W'(2));
      send_byte(8'h41);
      send_byte(8'h42);
      send_byte(8'h00);

      // over-range capacity with a long string; run this stretch without idling
      drain();
      pacing_on = 1'b0;
      write_capacity(CAP_W'(8191));
      repeat (LONG_STRING) send_byte(8'($urandom_range(1, 127)));
      send_byte(8'h00);
      drain();
      pacing_on = 1'b1;

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: cap_pick = CAP_W'($urandom_range(1, 40));
            5:             cap_pick = CAP_W'(256);
            6:             cap_pick = CAP_W'(MAX_CAPACITY);
            7:             cap_pick = CAP_W'($urandom_range(0, 8191));
            8:             cap_pick = CAP_W'(0);
            default:       cap_pick = CAP_W'(2);
         endcase
         drain();
         write_capacity(cap_pick);
         repeat ($urandom_range(2, 6)) send_random_string($urandom_range(0, 24));
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.units_due.size() != 0)
         sb.report($sformatf("%0d expected units never arrived", sb.units_due.size()));

      $display("Decoded %0d bytes into %0d units over %0d strings (%0d replacement units).",
               sb.bytes_seen, sb.units_seen, sb.strings_done, sb.replacements);
      $display("%0d capacity settings, %0d bytes dropped on a full buffer.",
               sb.capacity_writes, sb.dropped);
      if (sb.errors == 0)
         $display("utf8_to_utf16_bmp_decoder_test: PASS");
      else
         $display("utf8_to_utf16_bmp_decoder_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
